// ===== sv/rank_sum_u_statistic_top_macros.svh =====
// Assertion macros shared by the rank-sum block.
`ifndef RANK_SUM_U_STATISTIC_TOP_MACROS_SVH
`define RANK_SUM_U_STATISTIC_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RSU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rsu_pkg.sv =====
package rsu_pkg;

  localparam int MAX_ITEMS_DEF  = 256;
  localparam int VALUE_BITS_DEF = 32;
  localparam int SAMPLE_W       = 32;
  localparam int U_W            = 14;
  localparam int CNT_W          = 9;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       group;
    logic                       last;
  } rsu_in_t;

  typedef struct packed {
    logic [U_W-1:0]   u_statistic;
    logic [CNT_W-1:0] first_count;
    logic [CNT_W-1:0] second_count;
    logic             overflow;
  } rsu_out_t;

  // Control bits that travel with each value along the cell chain.
  typedef struct packed {
    logic valid;   // a transfer occupies this slot
    logic keep;    // the item was stored and counts toward the set
    logic placed;  // the item already sits in a cell (or never will)
    logic grp;     // 0 = first sample, 1 = second sample
    logic last;    // closes the data set
  } rsu_tag_t;

endpackage

// ===== sv/rsu_cell.sv =====
module rsu_cell
  import rsu_pkg::*;
#(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  rsu_tag_t                               tag_i,
  input  logic signed [VALUE_BITS-1:0]           value_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]         count_i,
  output rsu_tag_t                               tag_o,
  output logic signed [VALUE_BITS-1:0]           value_o,
  output logic [$clog2(MAX_ITEMS+1)-1:0]         count_o
);

  `include "rank_sum_u_statistic_top_macros.svh"

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic                         valid_q;
  logic                         grp_q;
  logic signed [VALUE_BITS-1:0] val_q;
  rsu_tag_t                     tag_q;
  rsu_tag_t                     tag_d;
  logic signed [VALUE_BITS-1:0] value_q;
  logic [CW-1:0]                count_q;
  logic                         hit;
  logic                         cap;

  // A pair (first x, second y) counts when y < x; equal values never count.
  always_comb begin
    hit = tag_i.valid && tag_i.keep && valid_q && (grp_q != tag_i.grp) &&
          (tag_i.grp ? (val_q > value_i) : (val_q < value_i));
    cap = tag_i.valid && tag_i.keep && !tag_i.placed && !valid_q;
    tag_d        = tag_i;
    tag_d.placed = tag_i.placed || cap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tag_q   <= '0;
    end else if (en_i) begin
      // The closing item empties the cell behind it for the next set.
      if (tag_i.valid && tag_i.last) begin
        valid_q <= 1'b0;
      end else if (cap) begin
        valid_q <= 1'b1;
      end
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cap) begin
        grp_q <= tag_i.grp;
        val_q <= value_i;
      end
      value_q <= value_i;
      count_q <= count_i + CW'(hit);
    end
  end

  assign tag_o   = tag_q;
  assign value_o = value_q;
  assign count_o = count_q;

  `RSU_ASSERT_NXT(a_cell_capture, clk_i, rst_ni, en_i && cap,
    valid_q || tag_q.last, "cell did not hold a captured value")

endmodule

// ===== sv/rsu_tally.sv =====
module rsu_tally
  import rsu_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  rsu_tag_t                        tag_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]  count_i,
  output logic                            out_valid_o,
  output rsu_out_t                        out_data_o
);

  `include "rank_sum_u_statistic_top_macros.svh"

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int UW = 2 * CW;

  logic [CW-1:0] n1_q, n2_q, n1_d, n2_d;
  logic [UW-1:0] u1_q, u1_d;
  logic          drop_q, drop_d;
  logic          fin_valid_q;
  logic [CW-1:0] fin_n1_q, fin_n2_q;
  logic [UW-1:0] fin_u1_q;
  logic          fin_drop_q;
  logic [UW-1:0] pairs, u2, u_min;
  logic          out_valid_q;
  rsu_out_t      out_q;
  logic          take;

  always_comb begin
    take   = tag_i.valid && tag_i.keep;
    n1_d   = n1_q + CW'(take && !tag_i.grp);
    n2_d   = n2_q + CW'(take && tag_i.grp);
    u1_d   = u1_q + UW'(count_i);
    drop_d = drop_q || (tag_i.valid && !tag_i.keep);
    pairs  = UW'(fin_n1_q) * UW'(fin_n2_q);
    u2     = pairs - fin_u1_q;
    u_min  = (fin_u1_q < u2) ? fin_u1_q : u2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_q        <= '0;
      n2_q        <= '0;
      u1_q        <= '0;
      drop_q      <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      fin_valid_q <= tag_i.valid && tag_i.last;
      out_valid_q <= fin_valid_q;
      if (tag_i.valid && tag_i.last) begin
        n1_q   <= '0;
        n2_q   <= '0;
        u1_q   <= '0;
        drop_q <= 1'b0;
      end else if (tag_i.valid) begin
        n1_q   <= n1_d;
        n2_q   <= n2_d;
        u1_q   <= u1_d;
        drop_q <= drop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (tag_i.valid && tag_i.last) begin
        fin_n1_q   <= n1_d;
        fin_n2_q   <= n2_d;
        fin_u1_q   <= u1_d;
        fin_drop_q <= drop_d;
      end
      if (fin_valid_q) begin
        out_q.u_statistic  <= U_W'(u_min);
        out_q.first_count  <= CNT_W'(fin_n1_q);
        out_q.second_count <= CNT_W'(fin_n2_q);
        out_q.overflow     <= fin_drop_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RSU_ASSERT_IMP(a_u1_bound, clk_i, rst_ni, fin_valid_q, fin_u1_q <= pairs,
    "U1 exceeds the number of cross-sample pairs")
  `RSU_ASSERT_NXT(a_fin_follows, clk_i, rst_ni, en_i && tag_i.valid && tag_i.last,
    fin_valid_q, "closing item did not produce a final tally")

endmodule

// ===== sv/rank_sum_u_statistic_top.sv =====
// Result path: MAX_ITEMS cells, then the tally's final and output registers.
// Throughput: one item per cycle; every item walks the full chain of MAX_ITEMS cells,
// one cell per cycle, and the whole chain holds while a finished result waits.
// Reset: asynchronous, active low; empties all cells and clears counts and flags.
// Stored values need no clearing pass: the closing item empties each cell it passes.
module rank_sum_u_statistic_top
  import rsu_pkg::*;
#(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rsu_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rsu_out_t out_data_o
);

  `include "rank_sum_u_statistic_top_macros.svh"

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic                         advance;
  logic                         in_acc;
  logic                         room;
  logic [CW-1:0]                held_q, held_d;
  logic signed [VALUE_BITS-1:0] head_value;
  rsu_tag_t                     head_tag;
  rsu_tag_t                     tag_w   [MAX_ITEMS+1];
  logic signed [VALUE_BITS-1:0] value_w [MAX_ITEMS+1];
  logic [CW-1:0]                count_w [MAX_ITEMS+1];

  generate
    if (VALUE_BITS <= SAMPLE_W) begin : g_narrow
      assign head_value = in_data_i.sample_value[VALUE_BITS-1:0];
    end else begin : g_wide
      assign head_value = {{(VALUE_BITS-SAMPLE_W){in_data_i.sample_value[SAMPLE_W-1]}},
                           in_data_i.sample_value};
    end
  endgenerate

  always_comb begin
    advance    = !out_valid_o || out_ready_i;
    in_ready_o = advance;
    in_acc     = in_valid_i && in_ready_o;
    room       = held_q < CW'(MAX_ITEMS);
    held_d     = held_q;
    if (in_acc) begin
      if (in_data_i.last) begin
        held_d = '0;
      end else if (room) begin
        held_d = held_q + CW'(1);
      end
    end
    head_tag.valid  = in_acc;
    head_tag.keep   = room;
    head_tag.placed = !room;
    head_tag.grp    = in_data_i.group;
    head_tag.last   = in_data_i.last;
  end

  assign tag_w[0]   = head_tag;
  assign value_w[0] = head_value;
  assign count_w[0] = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  generate
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_chain
      rsu_cell #(
        .MAX_ITEMS (MAX_ITEMS),
        .VALUE_BITS(VALUE_BITS)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (advance),
        .tag_i  (tag_w[i]),
        .value_i(value_w[i]),
        .count_i(count_w[i]),
        .tag_o  (tag_w[i+1]),
        .value_o(value_w[i+1]),
        .count_o(count_w[i+1])
      );
    end
  endgenerate

  rsu_tally #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_tally (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .tag_i      (tag_w[MAX_ITEMS]),
    .count_i    (count_w[MAX_ITEMS]),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  `RSU_ASSERT_IMP(a_held_range, clk_i, rst_ni, 1'b1, held_q <= CW'(MAX_ITEMS),
    "store fill count beyond depth")
  `RSU_ASSERT_NXT(a_set_restart, clk_i, rst_ni, in_acc && in_data_i.last,
    held_q == '0, "fill count not cleared after closing item")
  `RSU_ASSERT_IMP(a_drop_unplaced, clk_i, rst_ni, in_acc && !room,
    held_q == CW'(MAX_ITEMS), "item dropped while the store had room")

endmodule
